// ===== rtl/kpad_pkg.sv =====
// Shared types and constants for the keypad register and interrupt block.
// No dependencies; used by every module of the block.
package kpad_pkg;

   // number of keypad buttons (1 to 14)
   localparam int KPAD_NUM_BUTTONS = 10;

   // control register layout
   localparam int KPAD_CTL_W       = 16;
   localparam int KPAD_CTL_ENABLE  = 14;
   localparam int KPAD_CTL_AND     = 15;
   localparam logic [15:0] KPAD_CTL_HI_MASK = 16'hFF00;
   localparam logic [15:0] KPAD_CTL_LO_MASK = 16'h00FF;
   localparam logic [7:0]  KPAD_BYTE_MASK   = 8'hFF;

   // item operations
   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_SET_BUTTON  = 3'd1,
      OP_LOAD_MASK   = 3'd2,
      OP_RELEASE_ALL = 3'd3,
      OP_READ        = 3'd4,
      OP_WRITE       = 3'd5
   } kpad_op_type;

   // byte offsets
   localparam logic [1:0] OFF_KEY_LO = 2'd0;
   localparam logic [1:0] OFF_KEY_HI = 2'd1;
   localparam logic [1:0] OFF_CTL_LO = 2'd2;
   localparam logic [1:0] OFF_CTL_HI = 2'd3;

   // one result item
   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } kpad_rsp_type;

endpackage

// ===== rtl/keypad_register_interrupt_block.sv =====
// Keypad register and interrupt block: top level.
// The result of an item is registered in the result buffer and offered in order from its head.
// Throughput: one item per cycle while req_stall is low; a two-entry result buffer absorbs stalls.
// req_stall rises only when two results wait untaken.
// Synchronous active-high reset clears the button mask, control and flag.
// Depends on kpad_pkg, kpad_regs and kpad_out_buf.
module keypad_register_interrupt_block (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [3:0] req_button_index,
   input  logic       req_button_down,
   input  logic [9:0] req_press_mask,
   input  logic [1:0] req_byte_offset,
   input  logic [7:0] req_write_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_irq_request
);

   logic                   accept;
   logic                   full;
   kpad_pkg::kpad_rsp_type result;
   kpad_pkg::kpad_rsp_type rsp_data;

   // item handshake
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   // register file and interrupt logic
   kpad_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_opcode),
      .button_index (req_button_index),
      .button_down  (req_button_down),
      .press_mask   (req_press_mask),
      .byte_offset  (req_byte_offset),
      .write_byte   (req_write_byte),
      .result       (result)
   );

   // result buffer
   kpad_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_read_data   = rsp_data.read_data;
   assign rsp_irq_request = rsp_data.irq_request;

endmodule

// ===== rtl/kpad_regs.sv =====
// Keypad state registers, register access decode and interrupt edge detect.
// Depends on kpad_pkg.
module kpad_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [2:0]                opcode,
   input  logic [3:0]                button_index,
   input  logic                      button_down,
   input  logic [9:0]                press_mask,
   input  logic [1:0]                byte_offset,
   input  logic [7:0]                write_byte,
   output kpad_pkg::kpad_rsp_type    result
);

   logic [kpad_pkg::KPAD_NUM_BUTTONS-1:0] held_ff, held_in;
   logic [kpad_pkg::KPAD_CTL_W-1:0]       ctl_ff, ctl_in;
   logic                                  cond_ff, cond_in;
   logic [15:0]                           keys;
   logic [kpad_pkg::KPAD_NUM_BUTTONS-1:0] watched;
   logic [kpad_pkg::KPAD_NUM_BUTTONS-1:0] held_watched;
   logic                                  met;
   logic [7:0]                            rdata;

   // active-low key state, unused bits read as zero
   always_comb begin
      keys = '0;
      keys[kpad_pkg::KPAD_NUM_BUTTONS-1:0] = ~held_ff;
   end

   // next state and read data for one item
   always_comb begin
      held_in = held_ff;
      ctl_in  = ctl_ff;
      rdata   = 8'd0;
      case (kpad_pkg::kpad_op_type'(opcode))
         kpad_pkg::OP_SET_BUTTON: begin
            for (int i = 0; i < kpad_pkg::KPAD_NUM_BUTTONS; i++) begin
               if (button_index == 4'(i)) begin
                  held_in[i] = button_down;
               end
            end
         end
         kpad_pkg::OP_LOAD_MASK: begin
            held_in = kpad_pkg::KPAD_NUM_BUTTONS'(press_mask);
         end
         kpad_pkg::OP_RELEASE_ALL: begin
            held_in = '0;
         end
         kpad_pkg::OP_READ: begin
            case (byte_offset)
               kpad_pkg::OFF_KEY_LO: rdata = keys[7:0] & kpad_pkg::KPAD_BYTE_MASK;
               kpad_pkg::OFF_KEY_HI: rdata = keys[15:8] & kpad_pkg::KPAD_BYTE_MASK;
               kpad_pkg::OFF_CTL_LO: rdata = ctl_ff[7:0];
               default:              rdata = ctl_ff[15:8];
            endcase
         end
         kpad_pkg::OP_WRITE: begin
            case (byte_offset)
               kpad_pkg::OFF_CTL_LO:
                  ctl_in = (ctl_ff & kpad_pkg::KPAD_CTL_HI_MASK) | {8'd0, write_byte};
               kpad_pkg::OFF_CTL_HI:
                  ctl_in = (ctl_ff & kpad_pkg::KPAD_CTL_LO_MASK) | {write_byte, 8'd0};
               default: ctl_in = ctl_ff;
            endcase
         end
         default: ;
      endcase
   end

   // interrupt condition on the updated state
   assign watched      = ctl_in[kpad_pkg::KPAD_NUM_BUTTONS-1:0];
   assign held_watched = held_in & watched;
   always_comb begin
      if (!ctl_in[kpad_pkg::KPAD_CTL_ENABLE] || (watched == '0)) begin
         met = 1'b0;
      end else if (ctl_in[kpad_pkg::KPAD_CTL_AND]) begin
         met = (held_watched == watched);
      end else begin
         met = (held_watched != '0);
      end
   end

   assign cond_in            = met;
   assign result.read_data   = rdata;
   assign result.irq_request = met && !cond_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         ctl_ff  <= '0;
         cond_ff <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         ctl_ff  <= ctl_in;
         cond_ff <= cond_in;
      end
   end

`ifndef SYNTH
   // a request means the condition flag is set afterwards
   a_irq_sets_flag: assert property (@(posedge clock) disable iff (reset)
      accept && result.irq_request |=> cond_ff)
      else $error("irq request without condition flag");

   // flag is never held while interrupts are disabled
   a_flag_needs_enable: assert property (@(posedge clock) disable iff (reset)
      cond_ff |-> ctl_ff[kpad_pkg::KPAD_CTL_ENABLE])
      else $error("condition flag set while disabled");

   // state holds when no item is taken
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(held_ff) && $stable(ctl_ff) && $stable(cond_ff))
      else $error("state changed without an item");
`endif

endmodule

// ===== rtl/kpad_out_buf.sv =====
// Two-entry result buffer that decouples result stalls from item intake.
// Depends on kpad_pkg.
module kpad_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kpad_pkg::kpad_rsp_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kpad_pkg::kpad_rsp_type rsp_data
);

   kpad_pkg::kpad_rsp_type slot0_ff, slot0_in;
   kpad_pkg::kpad_rsp_type slot1_ff, slot1_in;
   logic [1:0]             count_ff, count_in;
   logic                   pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign full      = (count_ff == 2'd2);

   // slot update: slot0 is the head
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop && push) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTH
   // never more than two items held
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   // no push into a full buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full result buffer");

   // a held head item does not change while stalled
   a_head_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
`endif

endmodule
